FILE: rtl/eltc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package eltc_pkg;

    localparam int ELEV_W    = 14;
    localparam int PCT_W     = 7;
    localparam int IDX_W     = 4;
    localparam int TEMP_W    = 15;
    localparam int CNT_W     = 5;
    localparam int CFG_IDX_W = 2;
    localparam int RING_W    = 17;
    localparam int RATIO_W   = 17;
    localparam int PERC_W    = 23;
    localparam int BASE_W    = 22;
    localparam int NUM_W     = 41;
    localparam int QIN_W     = 22;
    localparam int QPROD_W   = 45;

    localparam logic CMD_QUERY = 1'b0;
    localparam logic CMD_LOAD  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_DAY     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRIES = 2'd2;

    localparam logic [TEMP_W-1:0] DAY_RESET     = 15'd5500;
    localparam logic [TEMP_W-1:0] NIGHT_RESET   = 15'd3700;
    localparam logic [CNT_W-1:0]  ENTRIES_RESET = 5'd2;

    // 360 degrees in 1/64 degree
    localparam logic signed [RING_W-1:0] FULL_TURN = 17'sd23040;

    localparam logic [CNT_W-1:0]   DIV_LAST    = 5'd16;
    localparam logic [BASE_W-1:0]  PCT_SCALE   = 22'd100;
    // floor(x / 100) = (x * RECIP) >> RECIP_SHIFT, exact for x below 2^22
    localparam logic [22:0]        RECIP       = 23'd5368710;
    localparam int                 RECIP_SHIFT = 29;
    localparam logic [24:0]        SAT_LIMIT   = 25'd3276800;
    localparam logic [TEMP_W-1:0]  TEMP_SAT    = 15'd32767;

    typedef struct packed {
        logic                     command;
        logic [IDX_W-1:0]         entry_index;
        logic signed [ELEV_W-1:0] sun_elevation;
        logic [PCT_W-1:0]         temp_percent;
    } t_item;

    typedef struct packed {
        logic [TEMP_W-1:0] day_temp;
        logic [TEMP_W-1:0] night_temp;
        logic [CNT_W-1:0]  entries_in_use;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_SCAN,
        ST_DIV,
        ST_PERC,
        ST_MAP,
        ST_RECIP,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

FILE: rtl/eltc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module eltc_front #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire eltc_pkg::t_item i_item,
    output logic                o_busy,
    output logic                o_head_valid,
    output eltc_pkg::t_item     o_head,
    input  wire logic           i_pop
);

    eltc_pkg::t_item r_queue [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic [1:0]      n_count;
    logic            w_accept;
    logic            w_keep;
    logic            w_pop;

    assign o_busy       = (r_count == 2'd2);
    assign o_head_valid = (r_count != 2'd0);
    assign o_head       = r_queue[r_rd_ptr];
    assign w_accept     = i_start && !o_busy;
    // drop loads aimed past the table
    assign w_keep       = w_accept && ((i_item.command == eltc_pkg::CMD_QUERY) ||
                          (32'(i_item.entry_index) < 32'(MAX_ENTRIES)));
    assign w_pop        = i_pop && o_head_valid;

    always_comb begin
        n_count = r_count;
        if (w_keep && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (!w_keep && w_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_keep) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_keep) begin
            r_queue[r_wr_ptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/eltc_back.sv
`timescale 1ns / 1ps
`default_nettype none
module eltc_back #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire eltc_pkg::t_cfg  i_cfg,
    input  wire logic            i_head_valid,
    input  wire eltc_pkg::t_item i_head,
    output logic                 o_pop,
    output logic                 o_valid,
    output logic [14:0]          o_color_temp,
    output logic                 o_found
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic signed [13:0] mem_elev [MAX_ENTRIES];
    logic [6:0]         mem_pct  [MAX_ENTRIES];

    eltc_pkg::t_state   r_state;
    eltc_pkg::t_state   n_state;

    logic signed [13:0] r_rd_elev;
    logic [6:0]         r_rd_pct;
    logic signed [13:0] r_elev;
    logic [CW-1:0]      r_n;
    logic [CW-1:0]      r_idx;
    logic signed [16:0] r_upper;
    logic [6:0]         r_pu;
    logic signed [13:0] r_e0;
    logic [6:0]         r_p0;
    logic [6:0]         r_pl;
    logic               r_found;
    logic [16:0]        r_rem;
    logic [15:0]        r_wid;
    logic [16:0]        r_quo;
    logic [4:0]         r_cnt;
    logic [22:0]        r_perc;
    logic [21:0]        r_base;
    logic signed [40:0] r_num;
    logic               r_zero;
    logic               r_sat;
    logic [44:0]        r_qprod;
    logic               r_valid;
    logic [14:0]        r_temp;
    logic               r_out_found;

    logic               n_valid;
    logic [14:0]        n_temp;
    logic [CW-1:0]      w_n_cur;
    logic [AW-1:0]      w_rd_addr;
    logic               w_mem_we;
    logic [CW:0]        w_idx_inc;
    logic               w_last;
    logic signed [16:0] w_elev_ext;
    logic signed [16:0] w_e0_ext;
    logic signed [16:0] w_rd_ext;
    logic signed [16:0] w_lower;
    logic [6:0]         w_pl;
    logic               w_hit;
    logic signed [16:0] w_span;
    logic signed [16:0] w_offs;
    logic [16:0]        w_cand;
    logic               w_ge;
    logic [16:0]        w_rem_nx;
    logic signed [7:0]  w_pdiff;
    logic signed [25:0] w_perc;
    logic signed [15:0] w_tdiff;
    logic [24:0]        w_qin;

    always_comb begin
        if (32'(i_cfg.entries_in_use) > 32'(MAX_ENTRIES)) begin
            w_n_cur = CW'(MAX_ENTRIES);
        end else begin
            w_n_cur = CW'(i_cfg.entries_in_use);
        end
    end

    assign w_idx_inc  = {1'b0, r_idx} + (CW+1)'(1);
    assign w_last     = (r_idx == r_n);
    assign w_elev_ext = {{3{r_elev[13]}}, r_elev};
    assign w_e0_ext   = {{3{r_e0[13]}}, r_e0};
    assign w_rd_ext   = {{3{r_rd_elev[13]}}, r_rd_elev};
    assign w_lower    = w_last ? (w_e0_ext - eltc_pkg::FULL_TURN) : w_rd_ext;
    assign w_pl       = w_last ? r_p0 : r_rd_pct;
    assign w_hit      = (w_elev_ext <= r_upper) && (w_elev_ext >= w_lower);
    assign w_span     = r_upper - w_lower;
    assign w_offs     = w_elev_ext - w_lower;

    assign w_cand   = (r_cnt == 5'd0) ? r_rem : {r_rem[15:0], 1'b0};
    assign w_ge     = (w_cand >= {1'b0, r_wid});
    assign w_rem_nx = w_ge ? (w_cand - {1'b0, r_wid}) : w_cand;

    assign w_pdiff = $signed({1'b0, r_pu}) - $signed({1'b0, r_pl});
    assign w_perc  = 26'($signed({1'b0, r_quo})) * 26'(w_pdiff)
                   + $signed({3'b0, r_pl, 16'b0});
    assign w_tdiff = $signed({1'b0, i_cfg.day_temp}) - $signed({1'b0, i_cfg.night_temp});
    assign w_qin   = r_num[40:16];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            eltc_pkg::ST_IDLE: begin
                if (i_head_valid && (i_head.command == eltc_pkg::CMD_QUERY)) begin
                    n_state = (w_n_cur == '0) ? eltc_pkg::ST_DONE : eltc_pkg::ST_FIRST;
                end
            end
            eltc_pkg::ST_FIRST: begin
                n_state = eltc_pkg::ST_SCAN;
            end
            eltc_pkg::ST_SCAN: begin
                if (w_hit) begin
                    n_state = (w_span == '0) ? eltc_pkg::ST_PERC : eltc_pkg::ST_DIV;
                end else if (w_last) begin
                    n_state = eltc_pkg::ST_DONE;
                end
            end
            eltc_pkg::ST_DIV: begin
                if (r_cnt == eltc_pkg::DIV_LAST) begin
                    n_state = eltc_pkg::ST_PERC;
                end
            end
            eltc_pkg::ST_PERC:  n_state = eltc_pkg::ST_MAP;
            eltc_pkg::ST_MAP:   n_state = eltc_pkg::ST_RECIP;
            eltc_pkg::ST_RECIP: n_state = eltc_pkg::ST_DONE;
            eltc_pkg::ST_DONE:  n_state = eltc_pkg::ST_IDLE;
            default:            n_state = eltc_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop     = 1'b0;
        w_mem_we  = 1'b0;
        w_rd_addr = '0;
        n_valid   = 1'b0;
        n_temp    = '0;
        case (r_state)
            eltc_pkg::ST_IDLE: begin
                o_pop     = i_head_valid;
                w_mem_we  = i_head_valid && (i_head.command == eltc_pkg::CMD_LOAD);
                w_rd_addr = AW'(w_n_cur - CW'(1));
            end
            eltc_pkg::ST_FIRST: begin
                w_rd_addr = '0;
            end
            eltc_pkg::ST_SCAN: begin
                if (w_idx_inc < {1'b0, r_n}) begin
                    w_rd_addr = AW'(w_idx_inc);
                end
            end
            eltc_pkg::ST_DONE: begin
                n_valid = 1'b1;
                if (!r_found || r_zero) begin
                    n_temp = '0;
                end else if (r_sat) begin
                    n_temp = eltc_pkg::TEMP_SAT;
                end else begin
                    n_temp = r_qprod[eltc_pkg::RECIP_SHIFT +: 15];
                end
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem_elev[AW'(i_head.entry_index)] <= i_head.sun_elevation;
            mem_pct[AW'(i_head.entry_index)]  <= i_head.temp_percent;
        end
        r_rd_elev <= mem_elev[w_rd_addr];
        r_rd_pct  <= mem_pct[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= eltc_pkg::ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_valid) begin
            r_temp      <= n_temp;
            r_out_found <= r_found;
        end
        case (r_state)
            eltc_pkg::ST_IDLE: begin
                r_elev  <= i_head.sun_elevation;
                r_n     <= w_n_cur;
                r_idx   <= '0;
                r_found <= 1'b0;
                r_zero  <= 1'b1;
            end
            eltc_pkg::ST_FIRST: begin
                r_upper <= w_rd_ext + eltc_pkg::FULL_TURN;
                r_pu    <= r_rd_pct;
            end
            eltc_pkg::ST_SCAN: begin
                if (r_idx == '0) begin
                    r_e0 <= r_rd_elev;
                    r_p0 <= r_rd_pct;
                end
                if (w_hit) begin
                    r_found <= 1'b1;
                    r_pl    <= w_pl;
                    r_rem   <= {1'b0, w_offs[15:0]};
                    r_wid   <= w_span[15:0];
                    r_quo   <= '0;
                    r_cnt   <= '0;
                end else begin
                    r_upper <= w_lower;
                    r_pu    <= w_pl;
                    r_idx   <= w_idx_inc[CW-1:0];
                end
            end
            eltc_pkg::ST_DIV: begin
                r_rem <= w_rem_nx;
                r_quo <= {r_quo[15:0], w_ge};
                r_cnt <= r_cnt + 5'd1;
            end
            eltc_pkg::ST_PERC: begin
                r_perc <= w_perc[22:0];
                r_base <= 22'(i_cfg.night_temp) * eltc_pkg::PCT_SCALE;
            end
            eltc_pkg::ST_MAP: begin
                r_num <= 41'($signed({1'b0, r_perc})) * 41'(w_tdiff)
                       + 41'($signed({1'b0, r_base, 16'b0}));
            end
            eltc_pkg::ST_RECIP: begin
                r_zero  <= (r_num <= 41'sd0);
                r_sat   <= (w_qin >= eltc_pkg::SAT_LIMIT);
                r_qprod <= 45'(w_qin[21:0]) * 45'(eltc_pkg::RECIP);
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    assign o_valid      = r_valid;
    assign o_color_temp = r_temp;
    assign o_found      = r_out_found;

    a_valid_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == eltc_pkg::ST_DONE))
        else $error("result strobe without a finished query");

    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_color_temp == '0))
        else $error("missed query gave a nonzero temperature");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == eltc_pkg::ST_SCAN) |-> ((r_idx <= r_n) && (r_n != '0)))
        else $error("table walk ran past the entries in use");

    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == eltc_pkg::ST_DIV) |-> (r_cnt <= eltc_pkg::DIV_LAST))
        else $error("ratio divider overran its step count");

endmodule
`default_nettype wire

FILE: rtl/elevation_to_color_temperature_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Sun elevation to color temperature over a circular breakpoint table.
// Item channel: an item is taken at a clock edge with i_start high and o_busy
// low. i_command selects a load (write entry i_entry_index with i_sun_elevation
// and i_temp_percent, no result) or a query (i_sun_elevation only).
// Result channel: o_valid is high for one cycle with o_color_temp and o_found;
// the receiver cannot stall, so results are never held back.
// Config channel: i_cfg_valid with i_cfg_index and i_cfg_data; o_cfg_ready is
// always high. Index 0 day temperature, 1 night temperature, 2 entries in use.
// Write config only while no query is in flight.
// Timing: items pass through a two-deep queue to the execution unit, so
// o_busy only rises when two items wait. The unit writes a load from IDLE.
// A query steps through the states FIRST, SCAN, DIV, PERC, MAP, RECIP and
// DONE; SCAN walks k (1 to N+1) table intervals, one per cycle, and DIV is
// the bit-serial divider. A zero-width match skips the divider, a miss goes
// from SCAN straight to DONE and an empty table from IDLE to DONE. The result
// strobe is registered from DONE and comes the cycle after the unit finishes.
// Reset (synchronous, active low) clears the queue and loads the register
// defaults 5500 K, 3700 K and 2 entries; table contents are not cleared.
module elevation_to_color_temperature_top #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic               i_command,
    input  wire logic [3:0]         i_entry_index,
    input  wire logic signed [13:0] i_sun_elevation,
    input  wire logic [6:0]         i_temp_percent,
    output logic                    o_valid,
    output logic [14:0]             o_color_temp,
    output logic                    o_found,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [14:0]        i_cfg_data
);

    eltc_pkg::t_cfg  r_cfg;
    eltc_pkg::t_item w_item;
    eltc_pkg::t_item w_head;
    logic            w_head_valid;
    logic            w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.day_temp       <= eltc_pkg::DAY_RESET;
            r_cfg.night_temp     <= eltc_pkg::NIGHT_RESET;
            r_cfg.entries_in_use <= eltc_pkg::ENTRIES_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                eltc_pkg::REG_DAY:     r_cfg.day_temp       <= i_cfg_data;
                eltc_pkg::REG_NIGHT:   r_cfg.night_temp     <= i_cfg_data;
                eltc_pkg::REG_ENTRIES: r_cfg.entries_in_use <= i_cfg_data[4:0];
                default:               r_cfg                <= r_cfg;
            endcase
        end
    end

    assign w_item.command       = i_command;
    assign w_item.entry_index   = i_entry_index;
    assign w_item.sun_elevation = i_sun_elevation;
    assign w_item.temp_percent  = i_temp_percent;

    eltc_front #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_item       (w_item),
        .o_busy       (o_busy),
        .o_head_valid (w_head_valid),
        .o_head       (w_head),
        .i_pop        (w_pop)
    );

    eltc_back #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .o_color_temp (o_color_temp),
        .o_found      (o_found)
    );

endmodule
`default_nettype wire
